FILE: design/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int MAP_BYTES_MAX = 1024;
    localparam int ADDR_W        = $clog2(MAP_BYTES_MAX);
    localparam int CNT_W         = ADDR_W + 1;
    localparam int ENTRY_W       = 14;
    localparam int POS_W         = ADDR_W + 3;

    localparam logic [7:0] BYTE_FULL = 8'hff;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_LOAD  = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_ALLOC = 2'd2;
    localparam opcode_t OP_FREE  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam logic CFG_MAP_BYTES  = 1'b0;
    localparam logic CFG_INDEX_BASE = 1'b1;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         wdata;
    } ram_req_t;

endpackage

FILE: design/bffa_map_ram.sv
`timescale 1ns / 1ps

module bffa_map_ram (
    input  logic              aclk,
    input  bffa_pkg::ram_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem [bffa_pkg::MAP_BYTES_MAX];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/bitmap_first_fit_allocator_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake              Words
// s_       in         s_valid / s_ready      opcode, byte_index, byte_data, entry_index
// m_       out        m_valid / m_ready      status, granted_index, read_byte
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word at a time. Load and out-of-range words go straight to the result, read
// and free take a map read (then a write back for free), and allocate scans from byte 0
// to the first clear bit, or to the map size when full, scanning one map byte a cycle.
// Reset clears control state only; the map is undefined until loaded.
// A waiting result does not stop the next word; a finished word holds until m_ready
// frees the output register.

module bitmap_first_fit_allocator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [bffa_pkg::ADDR_W-1:0]  s_byte_index,
    input  logic [7:0]                   s_byte_data,
    input  logic [bffa_pkg::ENTRY_W-1:0] s_entry_index,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [bffa_pkg::ENTRY_W-1:0] m_granted_index,
    output logic [7:0]                   m_read_byte,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [bffa_pkg::CNT_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RMW,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [bffa_pkg::CNT_W-1:0]      map_bytes_reg;
    logic                            index_base_reg;
    logic [bffa_pkg::ADDR_W-1:0]     addr_reg;
    logic [2:0]                      bit_reg;
    logic [bffa_pkg::CNT_W-1:0]      scan_reg;
    logic                            chk_valid_reg;
    bffa_pkg::status_t               res_status_reg;
    logic [bffa_pkg::ENTRY_W-1:0]    res_granted_reg;
    logic [7:0]                      res_byte_reg;
    logic                            m_valid_reg;
    bffa_pkg::status_t               m_status_reg;
    logic [bffa_pkg::ENTRY_W-1:0]    m_granted_reg;
    logic [7:0]                      m_byte_reg;

    bffa_pkg::ram_req_t              ram_req;
    logic [7:0]                      ram_rdata;

    logic [bffa_pkg::CNT_W-1:0]      eff_n;
    logic                            s_fire;
    logic                            bidx_ok;
    logic [bffa_pkg::ENTRY_W-1:0]    free_pos;
    logic                            free_ok;
    logic                            found;
    logic [2:0]                      clear_bit;
    logic                            out_free;

    bffa_map_ram u_map (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_comb begin
        eff_n = map_bytes_reg;
        if (map_bytes_reg == '0) begin
            eff_n = bffa_pkg::CNT_W'(1);
        end else if (map_bytes_reg > bffa_pkg::CNT_W'(bffa_pkg::MAP_BYTES_MAX)) begin
            eff_n = bffa_pkg::CNT_W'(bffa_pkg::MAP_BYTES_MAX);
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign bidx_ok   = {1'b0, s_byte_index} < eff_n;
    assign free_pos  = s_entry_index - bffa_pkg::ENTRY_W'(index_base_reg);
    assign free_ok   = (s_entry_index >= bffa_pkg::ENTRY_W'(index_base_reg))
                       && (free_pos < bffa_pkg::ENTRY_W'({eff_n, 3'b000}));
    assign found     = chk_valid_reg && (ram_rdata != bffa_pkg::BYTE_FULL);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        clear_bit = 3'd0;
        for (int j = 7; j >= 0; j--) begin
            if (!ram_rdata[j]) begin
                clear_bit = 3'(j);
            end
        end
    end

    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.addr  = addr_reg;
        ram_req.wdata = ram_rdata;
        case (state_reg)
            S_IDLE: begin
                if (s_opcode == bffa_pkg::OP_FREE) begin
                    ram_req.addr = free_pos[bffa_pkg::POS_W-1:3];
                end else begin
                    ram_req.addr  = s_byte_index;
                    ram_req.wdata = s_byte_data;
                    ram_req.we    = s_fire && bidx_ok && (s_opcode == bffa_pkg::OP_LOAD);
                end
            end
            S_RMW: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = ram_rdata & ~(8'd1 << bit_reg);
            end
            S_SCAN: begin
                if (found) begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = ram_rdata | (8'd1 << clear_bit);
                end else begin
                    ram_req.addr = scan_reg[bffa_pkg::ADDR_W-1:0];
                end
            end
            default: begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            map_bytes_reg  <= bffa_pkg::CNT_W'(bffa_pkg::MAP_BYTES_MAX);
            index_base_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    bffa_pkg::CFG_MAP_BYTES:  map_bytes_reg  <= cfg_data;
                    bffa_pkg::CFG_INDEX_BASE: index_base_reg <= cfg_data[0];
                    default:                  map_bytes_reg  <= map_bytes_reg;
                endcase
            end

            if (state_reg == S_OUT && out_free) begin
                m_valid_reg   <= 1'b1;
                m_status_reg  <= res_status_reg;
                m_granted_reg <= res_granted_reg;
                m_byte_reg    <= res_byte_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        res_status_reg  <= bffa_pkg::ST_OK;
                        res_granted_reg <= '0;
                        res_byte_reg    <= '0;
                        addr_reg        <= s_byte_index;
                        scan_reg        <= '0;
                        chk_valid_reg   <= 1'b0;
                        case (s_opcode)
                            bffa_pkg::OP_LOAD: begin
                                if (!bidx_ok) begin
                                    res_status_reg <= bffa_pkg::ST_RANGE;
                                end
                                state_reg <= S_OUT;
                            end
                            bffa_pkg::OP_READ: begin
                                if (bidx_ok) begin
                                    state_reg <= S_READ;
                                end else begin
                                    res_status_reg <= bffa_pkg::ST_RANGE;
                                    state_reg      <= S_OUT;
                                end
                            end
                            bffa_pkg::OP_ALLOC: begin
                                state_reg <= S_SCAN;
                            end
                            default: begin
                                addr_reg <= free_pos[bffa_pkg::POS_W-1:3];
                                bit_reg  <= free_pos[2:0];
                                if (free_ok) begin
                                    state_reg <= S_RMW;
                                end else begin
                                    res_status_reg <= bffa_pkg::ST_RANGE;
                                    state_reg      <= S_OUT;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    res_byte_reg <= ram_rdata;
                    state_reg    <= S_OUT;
                end
                S_RMW: begin
                    state_reg <= S_OUT;
                end
                S_SCAN: begin
                    if (found) begin
                        res_granted_reg <= bffa_pkg::ENTRY_W'({addr_reg, clear_bit})
                                           + bffa_pkg::ENTRY_W'(index_base_reg);
                        chk_valid_reg   <= 1'b0;
                        state_reg       <= S_OUT;
                    end else if (scan_reg == eff_n) begin
                        res_status_reg <= bffa_pkg::ST_FULL;
                        chk_valid_reg  <= 1'b0;
                        state_reg      <= S_OUT;
                    end else begin
                        addr_reg      <= scan_reg[bffa_pkg::ADDR_W-1:0];
                        scan_reg      <= scan_reg + bffa_pkg::CNT_W'(1);
                        chk_valid_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_granted_reg;
    assign m_read_byte     = m_byte_reg;

endmodule
